FILE: hdl/button_debounce_autorepeat_top_assert.svh
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Shared concurrent assertion forms for the debounce block.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Antecedent in a cycle implies the consequent in the same cycle.
`define BDA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("debounce block assertion failed");

// Antecedent in a cycle implies the consequent in the next cycle.
`define BDA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("debounce block assertion failed");

`else

`define BDA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BDA_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/bda_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce package
// Payload types, configuration types and shared helpers.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int PIN_W       = 6;
  localparam int CNT_W       = 8;
  localparam int PCOUNT_W    = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam int NUM_SWITCHES_DEFAULT      = 6;
  localparam int SELECT_SWITCH_POS_DEFAULT = 5;

  localparam logic [CNT_W-1:0] TICK_PERIOD_RST   = 8'd249;
  localparam logic [CNT_W-1:0] DEBOUNCE_RST      = 8'd4;
  localparam logic [CNT_W-1:0] FIRST_REPEAT_RST  = 8'd20;
  localparam logic [CNT_W-1:0] REPEAT_RST        = 8'd5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TICK_PERIOD      = 2'd0,
    REG_DEBOUNCE_PERIODS = 2'd1,
    REG_FIRST_REPEAT     = 2'd2,
    REG_REPEAT_PERIODS   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] tick_period;
    logic [CNT_W-1:0] debounce_periods;
    logic [CNT_W-1:0] first_repeat_periods;
    logic [CNT_W-1:0] repeat_periods;
  } cfg_t;

  typedef struct packed {
    logic [PIN_W-1:0] pins_low_active;
    logic             timer_tick;
    logic             ack_changed;
    logic             ack_repeat;
  } in_t;

  typedef struct packed {
    logic [PIN_W-1:0]    button_state;
    logic [PIN_W-1:0]    changed_bits;
    logic                repeat_pending;
    logic                debouncing;
    logic [PCOUNT_W-1:0] pressed_count;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

FILE: hdl/bda_intf.sv
// ----------------------------------------------------------------------------
// Button debounce channel interfaces
// Valid/ready channels for poll beats and result beats.
// ----------------------------------------------------------------------------
interface bda_in_if
  import bda_pkg::*;
  ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bda_out_if
  import bda_pkg::*;
  ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/bda_cfg_regs.sv
// ----------------------------------------------------------------------------
// Button debounce configuration registers
// Holds the four timing registers written through the plain write port.
// ----------------------------------------------------------------------------
module bda_cfg_regs
  import bda_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_period          <= TICK_PERIOD_RST;
      cfg.debounce_periods     <= DEBOUNCE_RST;
      cfg.first_repeat_periods <= FIRST_REPEAT_RST;
      cfg.repeat_periods       <= REPEAT_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TICK_PERIOD:      cfg.tick_period          <= cfg_data;
        REG_DEBOUNCE_PERIODS: cfg.debounce_periods     <= cfg_data;
        REG_FIRST_REPEAT:     cfg.first_repeat_periods <= cfg_data;
        REG_REPEAT_PERIODS:   cfg.repeat_periods       <= cfg_data;
      endcase
    end
  end

endmodule

FILE: hdl/bda_in_stage.sv
// ----------------------------------------------------------------------------
// Button debounce input register
// Captures one poll beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module bda_in_stage
  import bda_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bda_in_if.sink inp,
  input  logic advance,
  output logic q_valid,
  output in_t  q_data
);

  assign inp.ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (inp.ready) begin
      q_valid <= inp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (inp.ready && inp.valid) begin
      q_data <= inp.data;
    end
  end

endmodule

FILE: hdl/bda_core.sv
// ----------------------------------------------------------------------------
// Button debounce core
// Debounce, compare timer and auto-repeat state, updated once per poll.
// ----------------------------------------------------------------------------
`include "button_debounce_autorepeat_top_assert.svh"

module bda_core
  import bda_pkg::*;
#(
  parameter int NUM_SWITCHES      = NUM_SWITCHES_DEFAULT,
  parameter int SELECT_SWITCH_POS = SELECT_SWITCH_POS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  in_t  poll,
  input  cfg_t cfg,
  output res_t result
);

  logic [PIN_W-1:0] stable_bits, stable_bits_next;
  logic [PIN_W-1:0] change_latch, change_latch_next;
  logic [CNT_W-1:0] debounce_count, debounce_count_next;
  logic [CNT_W-1:0] hold_count, hold_count_next;
  logic [CNT_W-1:0] period_count, period_count_next;
  logic period_flag, period_flag_next;
  logic timer_running, timer_running_next;
  logic debounce_active, debounce_active_next;
  logic initial_wait_armed, initial_wait_armed_next;
  logic repeating, repeating_next;
  logic repeat_flag, repeat_flag_next;

  logic [PIN_W-1:0] switch_mask;
  logic [PIN_W-1:0] button_mask;

  always_comb begin
    for (int i = 0; i < PIN_W; i++) begin
      switch_mask[i] = (i < NUM_SWITCHES);
      button_mask[i] = (i < NUM_SWITCHES) && (i != SELECT_SWITCH_POS);
    end
  end

  always_comb begin
    logic [CNT_W-1:0] tp;
    logic [CNT_W-1:0] pc_inc;
    logic [PIN_W-1:0] pressed;
    logic             run_logic;

    stable_bits_next        = stable_bits;
    change_latch_next       = poll.ack_changed ? '0 : change_latch;
    repeat_flag_next        = poll.ack_repeat ? 1'b0 : repeat_flag;
    debounce_count_next     = debounce_count;
    hold_count_next         = hold_count;
    period_count_next       = period_count;
    period_flag_next        = period_flag;
    timer_running_next      = timer_running;
    debounce_active_next    = debounce_active;
    initial_wait_armed_next = initial_wait_armed;
    repeating_next          = repeating;
    run_logic               = 1'b1;

    // Compare timer; a zero match value behaves as one.
    tp     = (cfg.tick_period == '0) ? CNT_W'(1) : cfg.tick_period;
    pc_inc = period_count + 1'b1;
    if (timer_running && poll.timer_tick) begin
      if (pc_inc >= tp) begin
        period_count_next = '0;
        period_flag_next  = 1'b1;
      end else begin
        period_count_next = pc_inc;
      end
    end

    if (debounce_active) begin
      if (period_flag_next) begin
        debounce_count_next = sat_inc(debounce_count);
        period_flag_next    = 1'b0;
      end
      if (debounce_count_next >= cfg.debounce_periods) begin
        timer_running_next   = 1'b0;
        debounce_active_next = 1'b0;
      end else begin
        run_logic = 1'b0;
      end
    end

    pressed = ~poll.pins_low_active & switch_mask;
    if (run_logic) begin
      change_latch_next = change_latch_next | ((pressed ^ stable_bits) & switch_mask);
      stable_bits_next  = pressed;
      if (change_latch_next != '0) begin
        period_count_next       = '0;
        period_flag_next        = 1'b0;
        timer_running_next      = 1'b1;
        debounce_active_next    = 1'b1;
        repeat_flag_next        = 1'b0;
        initial_wait_armed_next = 1'b0;
        repeating_next          = 1'b0;
        hold_count_next         = '0;
        debounce_count_next     = '0;
      end else if ((pressed & button_mask) != '0) begin
        if (initial_wait_armed) begin
          if (period_flag_next) begin
            hold_count_next  = sat_inc(hold_count);
            period_flag_next = 1'b0;
          end
          priority if (repeating && hold_count_next >= cfg.repeat_periods) begin
            repeat_flag_next = 1'b1;
            hold_count_next  = '0;
          end else if (hold_count_next >= cfg.first_repeat_periods) begin
            repeat_flag_next = 1'b1;
            repeating_next   = 1'b1;
            hold_count_next  = '0;
          end
        end else begin
          period_count_next       = '0;
          period_flag_next        = 1'b0;
          timer_running_next      = 1'b1;
          initial_wait_armed_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [PIN_W-1:0]    held;
    logic [PCOUNT_W-1:0] n;
    held = stable_bits_next & button_mask;
    n    = '0;
    for (int i = 0; i < PIN_W; i++) begin
      n = n + PCOUNT_W'(held[i]);
    end
    result.button_state   = stable_bits_next;
    result.changed_bits   = change_latch_next;
    result.repeat_pending = repeat_flag_next;
    result.debouncing     = debounce_active_next;
    result.pressed_count  = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_bits        <= '0;
      change_latch       <= '0;
      debounce_count     <= '0;
      hold_count         <= '0;
      period_count       <= '0;
      period_flag        <= 1'b0;
      timer_running      <= 1'b0;
      debounce_active    <= 1'b0;
      initial_wait_armed <= 1'b0;
      repeating          <= 1'b0;
      repeat_flag        <= 1'b0;
    end else if (step) begin
      stable_bits        <= stable_bits_next;
      change_latch       <= change_latch_next;
      debounce_count     <= debounce_count_next;
      hold_count         <= hold_count_next;
      period_count       <= period_count_next;
      period_flag        <= period_flag_next;
      timer_running      <= timer_running_next;
      debounce_active    <= debounce_active_next;
      initial_wait_armed <= initial_wait_armed_next;
      repeating          <= repeating_next;
      repeat_flag        <= repeat_flag_next;
    end
  end

  // The timer always runs while the debounce window is open.
  `BDA_ASSERT_IMP(a_window_timer, clk, rst, debounce_active, timer_running)
  // A latched change that is not acknowledged keeps the window open.
  `BDA_ASSERT_IMP(a_latch_window, clk, rst, change_latch != '0, debounce_active)
  // The hold counter only moves once the first-repeat delay is armed.
  `BDA_ASSERT_IMP(a_hold_idle, clk, rst, !initial_wait_armed, hold_count == '0)
  // A repeat is never raised from inside the debounce window.
  `BDA_ASSERT_NXT(a_repeat_rise, clk, rst, step && !repeat_flag && repeat_flag_next,
                  !debounce_active)

endmodule

FILE: hdl/bda_out_stage.sv
// ----------------------------------------------------------------------------
// Button debounce result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module bda_out_stage
  import bda_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t load_data,
  output logic free,
  bda_out_if.source res
);

  logic o_valid;

  assign free      = !o_valid || res.ready;
  assign res.valid = o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (free) begin
      o_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.data <= load_data;
    end
  end

endmodule

FILE: hdl/button_debounce_autorepeat_top.sv
// ----------------------------------------------------------------------------
// Button debouncer with auto-repeat
// One poll beat in, one result beat out, through an input and a result register.
// ----------------------------------------------------------------------------
// Each poll beat yields exactly one result beat. The block takes one poll per
// clock cycle for as long as results are taken. A poll waits in the input
// register until the result register is free. Then the single state update runs
// and its result enters the result register at the same edge. The result beat is
// therefore offered once its poll has passed the input and the result register.
// While a result waits, one more poll can enter the input register. After that,
// the input is held off until the result is taken. Configuration writes take
// effect on the next poll processed and are meant for idle periods.
module button_debounce_autorepeat_top
  import bda_pkg::*;
#(
  parameter int NUM_SWITCHES      = NUM_SWITCHES_DEFAULT,
  parameter int SELECT_SWITCH_POS = SELECT_SWITCH_POS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  bda_in_if.sink                 inp,
  bda_out_if.source              res,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  logic q_valid;
  in_t  q_data;
  logic out_free;
  logic advance;
  res_t core_result;

  // A poll moves through the core exactly when the result register can take it.
  assign advance = q_valid && out_free;

  bda_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bda_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .inp     (inp),
    .advance (advance),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  bda_core #(
    .NUM_SWITCHES      (NUM_SWITCHES),
    .SELECT_SWITCH_POS (SELECT_SWITCH_POS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .poll   (q_data),
    .cfg    (cfg),
    .result (core_result)
  );

  bda_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .load_data (core_result),
    .free      (out_free),
    .res       (res)
  );

endmodule
